[hw/rtl/ope_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ope_pkg
// Shared types, codes and the precedence table of the expression parser.
// ----------------------------------------------------------------------------
package ope_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int TOP_W       = $clog2(STACK_DEPTH + 1);
    localparam int MAX_RESULTS = 33;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    // Stack word: {value, tag}
    localparam int TAG_W   = 9;
    localparam int VALUE_W = 64;
    localparam int WORD_W  = VALUE_W + TAG_W;

    localparam logic [TAG_W-1:0] TAG_MARK = 9'h100;
    localparam logic [TAG_W-1:0] TAG_RED  = 9'h101;
    localparam logic [TAG_W-1:0] TAG_END  = 9'h003;

    // Token classes
    localparam logic [2:0] CL_ADD  = 3'd0;
    localparam logic [2:0] CL_MUL  = 3'd1;
    localparam logic [2:0] CL_OPND = 3'd2;
    localparam logic [2:0] CL_END  = 3'd3;
    localparam logic [2:0] CL_REL  = 3'd4;
    localparam logic [2:0] CL_EQ   = 3'd5;
    localparam logic [2:0] CL_LPAR = 3'd6;
    localparam logic [2:0] CL_RPAR = 3'd7;

    typedef enum logic [1:0] {
        KIND_OPERAND  = 2'd0,
        KIND_OPERATOR = 2'd1,
        KIND_STATUS   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        STS_ACCEPTED = 3'd0,
        STS_COMPLETE = 3'd1,
        STS_SYNTAX   = 3'd2,
        STS_UNDEF    = 3'd3,
        STS_PAREN    = 3'd4,
        STS_NORULE   = 3'd5,
        STS_OVERFLOW = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        REL_R = 3'd0,
        REL_S = 3'd1,
        REL_E = 3'd2,
        REL_O = 3'd3,
        REL_F = 3'd4
    } t_rel;

    // What one evaluation step decided to do
    typedef enum logic [2:0] {
        ACT_RED_OPND = 3'd0,
        ACT_RED_BIN  = 3'd1,
        ACT_RED_PAR  = 3'd2,
        ACT_SHIFT_1  = 3'd3,
        ACT_SHIFT_2  = 3'd4,
        ACT_PUSH     = 3'd5,
        ACT_FINISH   = 3'd6
    } t_act;

    typedef enum logic [3:0] {
        S_IDLE  = 4'd0,
        S_RD_A  = 4'd1,
        S_RD_B  = 4'd2,
        S_RD_C  = 4'd3,
        S_EVAL  = 4'd4,
        S_WRITE = 4'd5,
        S_EMIT  = 4'd6
    } t_state;

    // Row = topmost terminal class, column = incoming class
    localparam t_rel PREC [0:7][0:7] = '{
        '{REL_R, REL_S, REL_S, REL_R, REL_R, REL_R, REL_S, REL_R},
        '{REL_R, REL_R, REL_S, REL_R, REL_R, REL_R, REL_S, REL_R},
        '{REL_R, REL_R, REL_F, REL_R, REL_R, REL_R, REL_F, REL_R},
        '{REL_S, REL_S, REL_S, REL_O, REL_S, REL_S, REL_S, REL_F},
        '{REL_S, REL_S, REL_S, REL_R, REL_F, REL_F, REL_S, REL_R},
        '{REL_S, REL_S, REL_S, REL_R, REL_F, REL_F, REL_S, REL_R},
        '{REL_S, REL_S, REL_S, REL_F, REL_S, REL_S, REL_S, REL_E},
        '{REL_R, REL_R, REL_F, REL_R, REL_R, REL_R, REL_F, REL_R}
    };

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       rd_a;
        logic       rd_b;
        logic       cap_a;
        logic       cap_b;
        logic       eval;
        logic       wr;
        logic [1:0] wr_step;
        logic       top_upd;
        logic       emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_act eval_act;
        t_act act;
        logic out_free;
    } t_dp_status;

    function automatic logic is_term(input logic [TAG_W-1:0] tag, input logic [2:0] cls);
        return (!tag[8]) && (tag[2:0] == cls);
    endfunction

endpackage
`default_nettype wire

[hw/rtl/ope_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ope_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ope_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

[hw/rtl/ope_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ope_ctrl
// Sequencer: reads the stack window, evaluates, writes back, emits words.
// ----------------------------------------------------------------------------
module ope_ctrl
    import ope_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_dp,
    output t_cmd            o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_step, n_step;
    logic [1:0] last_step;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Number of stack writes for the pending action, minus one
    always_comb begin
        case (i_dp.act)
            ACT_SHIFT_2: last_step = 2'd2;
            ACT_SHIFT_1: last_step = 2'd1;
            default:     last_step = 2'd0;
        endcase
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        o_cmd         = '0;
        o_cmd.wr_step = r_step;
        o_in_ready    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD_A;
                end
            end
            S_RD_A: begin
                o_cmd.rd_a = 1'b1;
                n_state    = S_RD_B;
            end
            S_RD_B: begin
                o_cmd.rd_b  = 1'b1;
                o_cmd.cap_a = 1'b1;
                n_state     = S_RD_C;
            end
            S_RD_C: begin
                o_cmd.cap_b = 1'b1;
                n_state     = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_step     = 2'd0;
                n_state    = (i_dp.eval_act == ACT_FINISH) ? S_EMIT : S_WRITE;
            end
            S_WRITE: begin
                o_cmd.wr = 1'b1;
                if (r_step == last_step) begin
                    o_cmd.top_upd = 1'b1;
                    n_step        = 2'd0;
                    n_state       = (i_dp.act == ACT_RED_PAR) ? S_RD_A : S_EMIT;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            S_EMIT: begin
                if (i_dp.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_dp.act == ACT_RED_OPND || i_dp.act == ACT_RED_BIN) begin
                        n_state = S_RD_A;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/ope_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ope_dpath
// Datapath: token register, stack memory, window, decision and output word.
// ----------------------------------------------------------------------------
module ope_dpath
    import ope_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_dp_status              o_dp,
    input  wire logic [2:0]         i_token_class,
    input  wire logic [1:0]         i_token_sub,
    input  wire logic [VALUE_W-1:0] i_token_value,
    input  wire logic               i_is_variable,
    input  wire logic               i_var_found,
    input  wire logic               i_var_maybe_undef,
    input  wire logic               i_need_closing_paren,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [1:0]              o_out_kind,
    output logic [2:0]              o_out_class,
    output logic [1:0]              o_out_sub,
    output logic [VALUE_W-1:0]      o_out_value,
    output logic                    o_out_is_variable,
    output logic                    o_check_defined,
    output logic [2:0]              o_status,
    output logic                    o_last
);

    // Token
    logic [TAG_W-1:0]   r_tok_tag;
    logic [VALUE_W-1:0] r_tok_val;
    logic               r_need;

    // Stack control
    logic [TOP_W-1:0] r_top;
    logic             r_lwr;
    logic [CNT_W-1:0] r_n;

    // Window of the top four entries
    logic [TAG_W-1:0]   r_w1, r_w2, r_w3, r_w4;
    logic [VALUE_W-1:0] r_v1;

    t_act    r_act, eval_act;
    t_status r_code, eval_code;

    // Memory ports
    logic               we;
    logic [ADDR_W-1:0]  waddr, raddr_a, raddr_b, wbase;
    logic [WORD_W-1:0]  wdata, rdata_a, rdata_b;

    logic [2:0]        row;
    t_rel              rel;
    logic              full;
    logic [TOP_W:0]    top_ext;

    ope_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // Read addresses: pair below the top, then the next pair
    always_comb begin
        if (i_cmd.rd_b) begin
            raddr_a = ADDR_W'(r_top - TOP_W'(3));
            raddr_b = ADDR_W'(r_top - TOP_W'(4));
        end else begin
            raddr_a = ADDR_W'(r_top - TOP_W'(1));
            raddr_b = ADDR_W'(r_top - TOP_W'(2));
        end
    end

    // Write address and data per action and step
    always_comb begin
        we    = i_cmd.wr;
        wbase = (r_act == ACT_SHIFT_2) ? ADDR_W'(r_top - TOP_W'(1)) : ADDR_W'(r_top);
        waddr = wbase + ADDR_W'(i_cmd.wr_step);
        wdata = {{VALUE_W{1'b0}}, TAG_RED};
        case (r_act)
            ACT_RED_OPND: waddr = ADDR_W'(r_top - TOP_W'(2));
            ACT_RED_BIN,
            ACT_RED_PAR:  waddr = ADDR_W'(r_top - TOP_W'(4));
            ACT_SHIFT_1: begin
                wdata = (i_cmd.wr_step == 2'd0) ? {{VALUE_W{1'b0}}, TAG_MARK}
                                                : {r_tok_val, r_tok_tag};
            end
            ACT_SHIFT_2: begin
                if (i_cmd.wr_step == 2'd0) begin
                    wdata = {{VALUE_W{1'b0}}, TAG_MARK};
                end else if (i_cmd.wr_step == 2'd2) begin
                    wdata = {r_tok_val, r_tok_tag};
                end
            end
            ACT_PUSH: wdata = {r_tok_val, r_tok_tag};
            default: ;
        endcase
    end

    // Decide the next action from the window
    always_comb begin
        row       = r_w1[8] ? r_w2[2:0] : r_w1[2:0];
        rel       = PREC[row][r_tok_tag[2:0]];
        full      = r_n >= CNT_W'(MAX_RESULTS - 1);
        top_ext   = {1'b0, r_top};
        eval_act  = ACT_FINISH;
        eval_code = STS_SYNTAX;
        case (rel)
            REL_R: begin
                case (row)
                    CL_OPND: begin
                        if (r_top < TOP_W'(2) || !is_term(r_w1, CL_OPND)) begin
                            eval_code = STS_SYNTAX;
                        end else if (r_w1[5] && !r_w1[6]) begin
                            eval_code = STS_UNDEF;
                        end else if (r_w2 != TAG_MARK) begin
                            eval_code = STS_SYNTAX;
                        end else if (full) begin
                            eval_code = STS_OVERFLOW;
                        end else begin
                            eval_act = ACT_RED_OPND;
                        end
                    end
                    CL_ADD, CL_MUL, CL_REL, CL_EQ: begin
                        if (r_top < TOP_W'(4) || r_w1 != TAG_RED || !is_term(r_w2, row)
                            || r_w3 != TAG_RED || r_w4 != TAG_MARK) begin
                            eval_code = STS_SYNTAX;
                        end else if (full) begin
                            eval_code = STS_OVERFLOW;
                        end else begin
                            eval_act = ACT_RED_BIN;
                        end
                    end
                    CL_RPAR: begin
                        if (r_top < TOP_W'(4) || !is_term(r_w1, CL_RPAR) || r_w2 != TAG_RED
                            || !is_term(r_w3, CL_LPAR) || r_w4 != TAG_MARK) begin
                            eval_code = STS_SYNTAX;
                        end else begin
                            eval_act = ACT_RED_PAR;
                        end
                    end
                    default: eval_code = STS_NORULE;
                endcase
            end
            REL_S: begin
                if (top_ext + (TOP_W+1)'(2) > (TOP_W+1)'(STACK_DEPTH)) begin
                    eval_code = STS_OVERFLOW;
                end else begin
                    eval_act = r_w1[8] ? ACT_SHIFT_2 : ACT_SHIFT_1;
                end
            end
            REL_E: begin
                if (top_ext + (TOP_W+1)'(1) > (TOP_W+1)'(STACK_DEPTH)) begin
                    eval_code = STS_OVERFLOW;
                end else begin
                    eval_act = ACT_PUSH;
                end
            end
            REL_O: eval_code = (r_need && !r_lwr) ? STS_PAREN : STS_COMPLETE;
            default: eval_code = STS_SYNTAX;
        endcase
    end

    // Token, window and decision registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tok_tag <= {1'b0, i_var_maybe_undef, i_var_found, i_is_variable,
                          i_token_sub, i_token_class};
            r_tok_val <= i_token_value;
            r_need    <= i_need_closing_paren;
        end
        // Entry zero always reads as the end marker
        if (i_cmd.cap_a) begin
            r_w1 <= (r_top == TOP_W'(1)) ? TAG_END : rdata_a[TAG_W-1:0];
            r_v1 <= rdata_a[WORD_W-1:TAG_W];
            r_w2 <= (r_top == TOP_W'(2)) ? TAG_END : rdata_b[TAG_W-1:0];
        end
        if (i_cmd.cap_b) begin
            r_w3 <= (r_top == TOP_W'(3)) ? TAG_END : rdata_a[TAG_W-1:0];
            r_w4 <= (r_top == TOP_W'(4)) ? TAG_END : rdata_b[TAG_W-1:0];
        end
        if (i_cmd.eval) begin
            r_act  <= eval_act;
            r_code <= eval_code;
        end
    end

    // Stack pointer, paren memory and result count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= TOP_W'(1);
            r_lwr <= 1'b0;
            r_n   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_n <= '0;
            end
            if (i_cmd.top_upd) begin
                case (r_act)
                    ACT_RED_OPND: r_top <= r_top - TOP_W'(1);
                    ACT_RED_BIN,
                    ACT_RED_PAR:  r_top <= r_top - TOP_W'(3);
                    ACT_SHIFT_1,
                    ACT_SHIFT_2: begin
                        r_top <= r_top + TOP_W'(2);
                        r_lwr <= (r_tok_tag[2:0] == CL_RPAR);
                    end
                    ACT_PUSH: begin
                        r_top <= r_top + TOP_W'(1);
                        r_lwr <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.emit) begin
                if (r_act == ACT_FINISH) begin
                    r_top <= TOP_W'(1);
                end
                if (r_act == ACT_RED_OPND || r_act == ACT_RED_BIN) begin
                    r_n <= r_n + CNT_W'(1);
                end
            end
        end
    end

    // Output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    // Output word payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out_kind        <= KIND_STATUS;
            o_out_class       <= 3'd0;
            o_out_sub         <= 2'd0;
            o_out_value       <= '0;
            o_out_is_variable <= 1'b0;
            o_check_defined   <= 1'b0;
            o_status          <= STS_ACCEPTED;
            o_last            <= 1'b1;
            case (r_act)
                ACT_RED_OPND: begin
                    o_out_kind        <= KIND_OPERAND;
                    o_out_class       <= CL_OPND;
                    o_out_sub         <= r_w1[4:3];
                    o_out_value       <= r_v1;
                    o_out_is_variable <= r_w1[5];
                    o_check_defined   <= r_w1[5] & r_w1[7];
                    o_last            <= 1'b0;
                end
                ACT_RED_BIN: begin
                    o_out_kind  <= KIND_OPERATOR;
                    o_out_class <= r_w2[2:0];
                    o_out_sub   <= r_w2[4:3];
                    o_last      <= 1'b0;
                end
                ACT_FINISH: o_status <= r_code;
                default: ;
            endcase
        end
    end

    assign o_dp.eval_act = eval_act;
    assign o_dp.act      = r_act;
    assign o_dp.out_free = !o_out_valid || i_out_ready;

endmodule
`default_nettype wire

[hw/rtl/operator_precedence_expression_parser_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// operator_precedence_expression_parser_core
// Operator-precedence parser emitting postfix words and a status per token.
// ----------------------------------------------------------------------------
// Sequence: each evaluation step reads the stack window (RD_A, RD_B, RD_C)
//   and decides (EVAL); a reduction then writes and emits, a bracket pair
//   writes only, a shift or a push writes and emits, a finish emits only.
// Pacing: set by the two-port stack memory read of the four top entries, its
//   single write port and a free output word; new tokens are taken only in IDLE.
// Reset: stack holds only the end marker, no output word pending.
// ----------------------------------------------------------------------------
module operator_precedence_expression_parser_core
    import ope_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [2:0]         i_token_class,
    input  wire logic [1:0]         i_token_sub,
    input  wire logic [VALUE_W-1:0] i_token_value,
    input  wire logic               i_is_variable,
    input  wire logic               i_var_found,
    input  wire logic               i_var_maybe_undef,
    input  wire logic               i_need_closing_paren,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [1:0]              o_out_kind,
    output logic [2:0]              o_out_class,
    output logic [1:0]              o_out_sub,
    output logic [VALUE_W-1:0]      o_out_value,
    output logic                    o_out_is_variable,
    output logic                    o_check_defined,
    output logic [2:0]              o_status,
    output logic                    o_last
);

    t_cmd       cmd;
    t_dp_status dp;

    ope_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_dp       (dp),
        .o_cmd      (cmd)
    );

    ope_dpath u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_dp                 (dp),
        .i_token_class        (i_token_class),
        .i_token_sub          (i_token_sub),
        .i_token_value        (i_token_value),
        .i_is_variable        (i_is_variable),
        .i_var_found          (i_var_found),
        .i_var_maybe_undef    (i_var_maybe_undef),
        .i_need_closing_paren (i_need_closing_paren),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_out_kind           (o_out_kind),
        .o_out_class          (o_out_class),
        .o_out_sub            (o_out_sub),
        .o_out_value          (o_out_value),
        .o_out_is_variable    (o_out_is_variable),
        .o_check_defined      (o_check_defined),
        .o_status             (o_status),
        .o_last               (o_last)
    );

endmodule
`default_nettype wire
